@@ src/sle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and types of the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

	// number of keys the list can hold
	localparam int DEPTH = 16;

	// field widths
	localparam int KEY_W   = 32;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	// width of the fill count, able to hold DEPTH itself
	localparam int HELD_W = $clog2(DEPTH + 1);

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_SPARE  = 2'd3
	} cmd_t;

	// status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [KEY_W-1:0] key;
	} cell_ctl_t;

endpackage

@@ src/sorted_list_engine.sv @@
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while in_stall is low; every cell compares in
// parallel and the chain shifts by one slot in the same cycle, so nothing iterates.
// Reset clears the key count and the result valid flag; the stored keys
// and the result fields are not cleared, and keys are only read below the count.
// ----------------------------------------------------------------------------
// sorted_list_engine
// Sorted list of signed keys held in a chain of compare-and-shift cells,
// with insert, remove and search commands.
// ----------------------------------------------------------------------------
module sorted_list_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sle_pkg::CMD_W-1:0]          command,
	input  logic signed [sle_pkg::KEY_W-1:0]   key,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sle_pkg::STAT_W-1:0]         status,
	output logic [sle_pkg::POS_W-1:0]          position,
	output logic [sle_pkg::COUNT_W-1:0]        count
);
	import sle_pkg::*;

	logic                    accept;
	logic [HELD_W-1:0]       held_q;
	logic                    full;
	logic                    found;
	logic                    ins_ok;
	logic                    rem_ok;
	cell_ctl_t               ctl;
	logic signed [KEY_W-1:0] entry [DEPTH];
	logic [DEPTH-1:0]        lt;
	logic [DEPTH-1:0]        eq;
	logic [DEPTH-1:0]        here;
	logic [DEPTH-1:0]        valid;
	logic [POS_W-1:0]        at_pos;
	logic [STAT_W-1:0]       status_d;
	logic [POS_W-1:0]        pos_d;
	logic [HELD_W-1:0]       held_d;

	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic [POS_W-1:0]        position_q;
	logic [COUNT_W-1:0]      count_q;

	// handshake
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// occupancy of each slot
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid[i] = (HELD_W'(i) < held_q);
		end
	end

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [KEY_W-1:0] prev_e;
		logic signed [KEY_W-1:0] next_e;
		logic                    prev_l;
		if (i == 0) begin : g_first
			assign prev_e = key;
			assign prev_l = 1'b1;
		end else begin : g_mid
			assign prev_e = entry[i-1];
			assign prev_l = lt[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_e = entry[i];
		end else begin : g_inner
			assign next_e = entry[i+1];
		end
		sle_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (valid[i]),
			.prev_entry (prev_e),
			.prev_lt    (prev_l),
			.next_entry (next_e),
			.entry      (entry[i]),
			.lt         (lt[i]),
			.eq         (eq[i]),
			.here       (here[i])
		);
	end

	// boundary position and match
	always_comb begin
		at_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (here[i]) begin
				at_pos = at_pos | POS_W'(i);
			end
		end
	end

	assign found = |(eq & here);
	assign full  = (held_q == HELD_W'(DEPTH));

	// command decode
	always_comb begin
		ins_ok   = 1'b0;
		rem_ok   = 1'b0;
		status_d = ST_OK;
		pos_d    = '0;
		held_d   = held_q;
		case (command)
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_ok = 1'b1;
					pos_d  = at_pos;
					held_d = held_q + HELD_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					rem_ok = 1'b1;
					pos_d  = at_pos;
					held_d = held_q - HELD_W'(1);
				end else begin
					status_d = ST_MISSING;
				end
			end
			default: begin
				if (found) begin
					pos_d = at_pos;
				end else begin
					status_d = ST_MISSING;
				end
			end
		endcase
	end

	assign ctl.ins = accept && ins_ok;
	assign ctl.rem = accept && rem_ok;
	assign ctl.key = key;

	// fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept || (out_valid_q && out_stall);
			if (accept) begin
				held_q <= held_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status_d;
			position_q <= pos_d;
			count_q    <= COUNT_W'(held_d);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign count     = count_q;

	// checks
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(DEPTH))
		else $error("key count exceeds depth");

	a_one_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(here))
		else $error("more than one insert boundary in the chain");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> position == '0)
		else $error("nonzero position on failed command");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> held_q == $past(held_q) + HELD_W'(1))
		else $error("insert did not raise the key count");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

endmodule

@@ src/sle_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted chain: holds a key, compares it against the
// broadcast key and shifts toward or away from its neighbors on update.
// ----------------------------------------------------------------------------
module sle_cell (
	input  logic                               clk,
	input  sle_pkg::cell_ctl_t                 ctl,
	input  logic                               valid,
	input  logic signed [sle_pkg::KEY_W-1:0]   prev_entry,
	input  logic                               prev_lt,
	input  logic signed [sle_pkg::KEY_W-1:0]   next_entry,
	output logic signed [sle_pkg::KEY_W-1:0]   entry,
	output logic                               lt,
	output logic                               eq,
	output logic                               here
);
	import sle_pkg::*;

	logic signed [KEY_W-1:0] entry_q;

	// compare held key against the broadcast key
	assign lt   = valid && (entry_q < ctl.key);
	assign eq   = valid && (entry_q == ctl.key);
	// first slot that is not below the key
	assign here = !lt && prev_lt;

	assign entry = entry_q;

	// insert opens a gap at the boundary, remove closes it
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (here) begin
				entry_q <= ctl.key;
			end else if (!lt) begin
				entry_q <= prev_entry;
			end
		end else if (ctl.rem) begin
			if (!lt) begin
				entry_q <= next_entry;
			end
		end
	end

endmodule
